/* rtl/ddb_pkg.sv */
// Types and constants shared by the dotted-decimal to bytes converter.
// No dependencies.
package ddb_pkg;

    localparam int CHAR_W  = 8;
    localparam int SEP_W   = 9;
    localparam int IDX_W   = 7;
    localparam int CFG_A_W = 3;

    localparam logic [1:0] FMT_ANY   = 2'd0;
    localparam logic [1:0] FMT_DOT   = 2'd1;
    localparam logic [1:0] FMT_SLASH = 2'd2;

    localparam logic [SEP_W-1:0]  SEP_NONE     = 9'h1FF;
    localparam logic [CHAR_W-1:0] DOT_RST      = 8'd46;
    localparam logic [CHAR_W-1:0] SLASH_RST    = 8'd47;
    localparam logic [CHAR_W-1:0] ZERO_RST     = 8'd48;
    localparam logic [CHAR_W-1:0] NINE_RST     = 8'd57;
    localparam logic [11:0]       BYTE_LIMIT   = 12'd256;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_FIELD_SEP  = 3'd0,
        CFG_RECORD_SEP = 3'd1,
        CFG_DOT_CHAR   = 3'd2,
        CFG_SLASH_CHAR = 3'd3,
        CFG_DIGIT_ZERO = 3'd4,
        CFG_DIGIT_NINE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SEP_W-1:0]  field_sep;
        logic [SEP_W-1:0]  record_sep;
        logic [CHAR_W-1:0] dot_char;
        logic [CHAR_W-1:0] slash_char;
        logic [CHAR_W-1:0] digit_zero;
        logic [CHAR_W-1:0] digit_nine;
    } ddb_cfg_t;

    typedef struct packed {
        logic              byte_valid;
        logic [CHAR_W-1:0] byte_value;
        logic [IDX_W-1:0]  byte_index;
        logic              done_res;
        logic              error;
        logic [IDX_W-1:0]  part_count;
        logic              format;
    } ddb_res_t;

endpackage

/* rtl/ddb_cfg.sv */
// Configuration register file for the converter.
// Depends on ddb_pkg.
module ddb_cfg
    import ddb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_A_W-1:0]       cfg_addr,
    input  logic [SEP_W-1:0]         cfg_wdata,
    output ddb_cfg_t                 cfg
);

    ddb_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.field_sep  <= SEP_NONE;
            cfg_reg.record_sep <= SEP_NONE;
            cfg_reg.dot_char   <= DOT_RST;
            cfg_reg.slash_char <= SLASH_RST;
            cfg_reg.digit_zero <= ZERO_RST;
            cfg_reg.digit_nine <= NINE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FIELD_SEP:  cfg_reg.field_sep  <= cfg_wdata;
                CFG_RECORD_SEP: cfg_reg.record_sep <= cfg_wdata;
                CFG_DOT_CHAR:   cfg_reg.dot_char   <= cfg_wdata[CHAR_W-1:0];
                CFG_SLASH_CHAR: cfg_reg.slash_char <= cfg_wdata[CHAR_W-1:0];
                CFG_DIGIT_ZERO: cfg_reg.digit_zero <= cfg_wdata[CHAR_W-1:0];
                CFG_DIGIT_NINE: cfg_reg.digit_nine <= cfg_wdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ddb_parse.sv */
// Per-character parse state and result logic.
// Depends on ddb_pkg.
module ddb_parse
    import ddb_pkg::*;
#(
    parameter int MAX_PARTS = 127
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_en,
    input  logic [CHAR_W-1:0] ch,
    input  logic              start_req,
    input  logic              end_is_record,
    input  logic [1:0]        required_format,
    input  ddb_cfg_t          cfg,
    output ddb_res_t          res
);

    localparam logic [IDX_W:0] MAX_P = (IDX_W+1)'(MAX_PARTS);

    logic              busy_reg, busy_next;
    logic [CHAR_W-1:0] accum_reg, accum_next;
    logic              has_digit_reg, has_digit_next;
    logic [IDX_W-1:0]  part_index_reg, part_index_next;
    logic              slash_seen_reg, slash_seen_next;
    logic              want_rec_reg, want_rec_next;
    logic [1:0]        want_fmt_reg, want_fmt_next;

    logic        f_match, r_match, need_match, fmt_bad, is_dot, is_slash;
    logic [11:0] sum;
    logic [IDX_W:0] idx_inc;

    assign f_match  = !cfg.field_sep[SEP_W-1] && (cfg.field_sep[CHAR_W-1:0] == ch);
    assign r_match  = !cfg.record_sep[SEP_W-1] && (cfg.record_sep[CHAR_W-1:0] == ch);
    assign is_dot   = (ch == cfg.dot_char);
    assign is_slash = (ch == cfg.slash_char);

    always_comb begin
        busy_next       = busy_reg;
        accum_next      = accum_reg;
        has_digit_next  = has_digit_reg;
        part_index_next = part_index_reg;
        slash_seen_next = slash_seen_reg;
        want_rec_next   = want_rec_reg;
        want_fmt_next   = want_fmt_reg;
        if (start_req) begin
            busy_next       = 1'b1;
            accum_next      = '0;
            has_digit_next  = 1'b0;
            part_index_next = '0;
            slash_seen_next = 1'b0;
            want_rec_next   = end_is_record;
            want_fmt_next   = required_format;
        end

        need_match = want_rec_next ? r_match : f_match;
        fmt_bad    = (want_fmt_next == FMT_DOT && slash_seen_next)
                  || (want_fmt_next == FMT_SLASH && !slash_seen_next);
        idx_inc    = {1'b0, part_index_next} + (IDX_W+1)'(1);
        // accum * 10 + digit
        sum        = {1'b0, accum_next, 3'b000} + {3'b000, accum_next, 1'b0}
                   + {4'b0000, ch - cfg.digit_zero};

        res = '0;
        if (busy_next) begin
            if (f_match || r_match) begin
                if (!has_digit_next || !need_match || fmt_bad) begin
                    res.error = 1'b1;
                end else begin
                    busy_next      = 1'b0;
                    res.byte_valid = 1'b1;
                    res.byte_value = accum_next;
                    res.byte_index = part_index_next;
                    res.done_res   = 1'b1;
                    res.part_count = idx_inc[IDX_W-1:0];
                    res.format     = slash_seen_next;
                end
            end else if (is_dot || is_slash) begin
                if (!has_digit_next || slash_seen_next || idx_inc >= MAX_P) begin
                    res.error = 1'b1;
                end else begin
                    res.byte_valid  = 1'b1;
                    res.byte_value  = accum_next;
                    res.byte_index  = part_index_next;
                    slash_seen_next = is_slash;
                    part_index_next = idx_inc[IDX_W-1:0];
                    accum_next      = '0;
                    has_digit_next  = 1'b0;
                end
            end else if (ch < cfg.digit_zero || ch > cfg.digit_nine) begin
                res.error = 1'b1;
            end else if (has_digit_next && accum_next == '0) begin
                res.error = 1'b1;      // leading zero
            end else if (sum >= BYTE_LIMIT) begin
                res.error = 1'b1;
            end else begin
                accum_next     = sum[CHAR_W-1:0];
                has_digit_next = 1'b1;
            end
            if (res.error) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            accum_reg      <= '0;
            has_digit_reg  <= 1'b0;
            part_index_reg <= '0;
            slash_seen_reg <= 1'b0;
            want_rec_reg   <= 1'b0;
            want_fmt_reg   <= FMT_ANY;
        end else if (in_en) begin
            busy_reg       <= busy_next;
            accum_reg      <= accum_next;
            has_digit_reg  <= has_digit_next;
            part_index_reg <= part_index_next;
            slash_seen_reg <= slash_seen_next;
            want_rec_reg   <= want_rec_next;
            want_fmt_reg   <= want_fmt_next;
        end
    end

endmodule

/* rtl/ddb_out.sv */
// Result register with a one-entry skid stage.
// Depends on ddb_pkg.
module ddb_out
    import ddb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_en,
    input  ddb_res_t in_res,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ddb_res_t out_res
);

    ddb_res_t out_reg, skid_reg;
    logic     out_valid_reg, skid_valid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !out_ready) begin
            if (in_en) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= in_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !out_ready) begin
            if (in_en) begin
                skid_reg <= in_res;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (in_en) begin
            out_reg <= in_res;
        end
    end

endmodule

/* rtl/dotted_decimal_to_bytes.sv */
// Dotted-decimal to bytes converter, top level.
// Depends on ddb_pkg, ddb_cfg, ddb_parse and ddb_out.
//
// Takes one character per request (n.n.n or n.n/n, parts 0..255, no leading
// zeros) and returns exactly one result per request: a byte as each dot or
// slash arrives, byte plus done with part count and format on the required
// separator, an error for any malformed value, or an all-zero result when
// nothing is emitted. One request is taken every cycle while s_tready is
// high, and its result is registered for the m_ side. The parse state
// (accumulator, part index, slash flag) updates once per accepted character.
// A skid entry lets one more request in while a result waits. Configuration
// must be written only while the block is idle; the block does not enforce it.
module dotted_decimal_to_bytes
    import ddb_pkg::*;
#(
    parameter int MAX_PARTS = 127
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [SEP_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // ch[7:0]
    input  logic [3:0]         s_tuser,   // start_req, end_is_record, required_format[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // byte_value, byte_index, part_count, format, pad
    output logic [2:0]         m_tuser    // byte_valid, done_res, error
);

    ddb_cfg_t cfg;
    ddb_res_t res, out_res;
    logic     accept;

    assign accept = s_tvalid && s_tready;

    ddb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ddb_parse #(
        .MAX_PARTS (MAX_PARTS)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_en           (accept),
        .ch              (s_tdata),
        .start_req       (s_tuser[0]),
        .end_is_record   (s_tuser[1]),
        .required_format (s_tuser[3:2]),
        .cfg             (cfg),
        .res             (res)
    );

    ddb_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_en     (accept),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.format, out_res.part_count,
                      out_res.byte_index, out_res.byte_value};
    assign m_tuser = {out_res.error, out_res.done_res, out_res.byte_valid};

    // error result carries nothing else
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == '0 && m_tuser[1:0] == 2'b00)
        else $error("error result with payload");

    // done always carries the last byte and a matching count
    a_done_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tuser[0] && m_tdata[21:15] == m_tdata[14:8] + 7'd1)
        else $error("done without consistent last byte");

    // skid entry only fills behind a held result
    a_skid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a stalled result with a fresh request fills the skid entry
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready)
        else $error("skid entry not filled");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for dotted_decimal_to_bytes: a directed table, then random
// values over several separator and digit settings, checked against a local parser.
// Depends on ddb_pkg and the dotted_decimal_to_bytes RTL.
module tb;
    import ddb_pkg::*;

    localparam int PARTS_MAX = 127;
    localparam int LIMIT     = 400000;
    localparam int DIR_N     = 29;

    localparam ddb_res_t NO_RES  = '0;
    localparam ddb_res_t ERR_RES = ddb_res_t'({1'b0, 8'd0, 7'd0, 1'b0, 1'b1, 7'd0, 1'b0});

    typedef struct packed {
        logic [7:0] ch;
        logic       st;
        logic       rec;
        logic [1:0] fmt;
        logic       typed;
        ddb_res_t   res;
    } dir_row_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr  = '0;
    logic [SEP_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;
    logic [3:0]         s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;
    logic [2:0]         m_tuser;

    dotted_decimal_to_bytes dut (.*);

    always #4 aclk = ~aclk;

    // parser copy: config and parse state
    ddb_cfg_t   cfg_m;
    logic       pr_busy, pr_hasd, pr_slash, pr_rec;
    logic [7:0] pr_acc;
    logic [6:0] pr_idx;
    logic [1:0] pr_fmt;

    ddb_res_t pending_res[$];
    ddb_res_t got, want;
    dir_row_t dir_tab [DIR_N];
    int       fails = 0;
    int       cycles = 0;
    int       value_chars = 0;
    int       hold_req = 0;
    int       stall = 0;
    bit       no_idle = 0;

    function automatic ddb_res_t mk_res(bit bv, int val, int idx, bit dn, bit er, int cnt, bit fm);
        ddb_res_t r;
        r.byte_valid = bv;
        r.byte_value = val[7:0];
        r.byte_index = idx[6:0];
        r.done_res   = dn;
        r.error      = er;
        r.part_count = cnt[6:0];
        r.format     = fm;
        return r;
    endfunction

    function automatic bit sep_hit(logic [8:0] sep, logic [7:0] c);
        return !sep[8] && sep[7:0] == c;
    endfunction

    function automatic ddb_res_t reject();
        pr_busy = 1'b0;
        return ERR_RES;
    endfunction

    function automatic ddb_res_t parse_step(logic [7:0] c, bit st, bit rec, logic [1:0] fmt);
        logic [8:0] need;
        int         nxt;
        ddb_res_t   r;
        if (st) begin
            pr_busy = 1'b1; pr_acc = '0; pr_hasd = 1'b0; pr_idx = '0; pr_slash = 1'b0;
            pr_rec = rec;
            pr_fmt = fmt;
        end
        if (!pr_busy) return NO_RES;
        if (sep_hit(cfg_m.field_sep, c) || sep_hit(cfg_m.record_sep, c)) begin
            need = pr_rec ? cfg_m.record_sep : cfg_m.field_sep;
            if (!pr_hasd || !sep_hit(need, c)) return reject();
            if ((pr_fmt == FMT_DOT && pr_slash) || (pr_fmt == FMT_SLASH && !pr_slash))
                return reject();
            pr_busy = 1'b0;
            return mk_res(1, pr_acc, pr_idx, 1, 0, int'(pr_idx) + 1, pr_slash);
        end
        if (c == cfg_m.dot_char || c == cfg_m.slash_char) begin
            if (!pr_hasd || pr_slash) return reject();
            if (int'(pr_idx) + 1 >= PARTS_MAX) return reject();
            if (c == cfg_m.slash_char) pr_slash = 1'b1;
            r = mk_res(1, pr_acc, pr_idx, 0, 0, 0, 0);
            pr_idx  = pr_idx + 7'd1;
            pr_acc  = '0;
            pr_hasd = 1'b0;
            return r;
        end
        if (c < cfg_m.digit_zero || c > cfg_m.digit_nine) return reject();
        if (pr_hasd && pr_acc == 0) return reject();
        nxt = int'(pr_acc) * 10 + (int'(c) - int'(cfg_m.digit_zero));
        if (nxt >= 256) return reject();
        pr_acc  = nxt[7:0];
        pr_hasd = 1'b1;
        return NO_RES;
    endfunction

    function automatic logic [7:0] digit_code(int d);
        return cfg_m.digit_zero + d[7:0];
    endfunction

    task automatic send_char(logic [7:0] c, bit st, bit rec, logic [1:0] fmt,
                             bit typed, ddb_res_t typed_res);
        ddb_res_t r;
        int       gap;
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= {fmt, rec, st};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = parse_step(c, st, rec, fmt);
        pending_res.push_back(typed ? typed_res : r);
    endtask

    task automatic send_value(int nparts, bit clean);
        logic [7:0] txt[$];
        logic [8:0] end_sep;
        logic [1:0] fmt;
        bit         rec, slash_last;
        int         kind, bad_part, v, p;
        rec = 1'($urandom_range(0, 1));
        if (nparts == 0) nparts = $urandom_range(1, 6);
        slash_last = nparts > 1 && $urandom_range(0, 2) == 0;
        if (clean || $urandom_range(0, 3) != 0)
            fmt = slash_last ? FMT_SLASH : ($urandom_range(0, 1) ? FMT_DOT : FMT_ANY);
        else
            fmt = 2'($urandom_range(0, 3));
        kind = -1;
        if (!clean && $urandom_range(0, 2) == 0) kind = $urandom_range(0, 4);
        bad_part = $urandom_range(0, nparts - 1);
        for (p = 0; p < nparts; p++) begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 255;
                2:       v = $urandom_range(0, 9);
                3:       v = $urandom_range(10, 99);
                default: v = $urandom_range(0, 255);
            endcase
            // long values use single-digit parts
            if (nparts > 6) v = $urandom_range(0, 9);
            if (p == bad_part) begin
                if (kind == 1) v = $urandom_range(256, 999);
                if (kind == 2) txt.push_back(digit_code(0));
                if (kind == 3) txt.push_back(cfg_m.dot_char);
            end
            if (v >= 100) txt.push_back(digit_code(v / 100));
            if (v >= 10) txt.push_back(digit_code((v / 10) % 10));
            txt.push_back(digit_code(v % 10));
            if (p < nparts - 1) begin
                if ((p == nparts - 2 && slash_last) || (!clean && $urandom_range(0, 19) == 0))
                    txt.push_back(cfg_m.slash_char);
                else
                    txt.push_back(cfg_m.dot_char);
            end
        end
        end_sep = (rec ^ (kind == 4)) ? cfg_m.record_sep : cfg_m.field_sep;
        txt.push_back(end_sep[8] ? 8'($urandom_range(0, 255)) : end_sep[7:0]);
        if (kind == 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        for (p = 0; p < txt.size(); p++)
            send_char(txt[p], p == 0, rec, fmt, 1'b0, NO_RES);
        value_chars += txt.size();
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_put(cfg_idx_t idx, logic [8:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FIELD_SEP:  cfg_m.field_sep  = val;
            CFG_RECORD_SEP: cfg_m.record_sep = val;
            CFG_DOT_CHAR:   cfg_m.dot_char   = val[7:0];
            CFG_SLASH_CHAR: cfg_m.slash_char = val[7:0];
            CFG_DIGIT_ZERO: cfg_m.digit_zero = val[7:0];
            CFG_DIGIT_NINE: cfg_m.digit_nine = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [8:0] fs, logic [8:0] rs, logic [7:0] dc,
                              logic [7:0] sc, logic [7:0] zc, logic [7:0] nc);
        settle();
        cfg_put(CFG_FIELD_SEP, fs);
        cfg_put(CFG_RECORD_SEP, rs);
        cfg_put(CFG_DOT_CHAR, {1'b0, dc});
        cfg_put(CFG_SLASH_CHAR, {1'b0, sc});
        cfg_put(CFG_DIGIT_ZERO, {1'b0, zc});
        cfg_put(CFG_DIGIT_NINE, {1'b0, nc});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // result side
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            stall = hold_req;
            hold_req = 0;
        end
        if (stall > 0) begin
            m_tready <= 1'b0;
            stall--;
        end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            stall = $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_value = m_tdata[7:0];
            got.byte_index = m_tdata[14:8];
            got.part_count = m_tdata[21:15];
            got.format     = m_tdata[22];
            got.byte_valid = m_tuser[0];
            got.done_res   = m_tuser[1];
            got.error      = m_tuser[2];
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result tdata %h tuser %h", $time, m_tdata, m_tuser);
                fails++;
            end else begin
                want = pending_res.pop_front();
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("byte_value", want.byte_value, got.byte_value);
                check_field("byte_index", want.byte_index, got.byte_index);
                check_field("done_res", want.done_res, got.done_res);
                check_field("error", want.error, got.error);
                check_field("part_count", want.part_count, got.part_count);
                check_field("format", want.format, got.format);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        int ph, mark, span;
        cfg_m = '{field_sep: SEP_NONE, record_sep: SEP_NONE, dot_char: DOT_RST,
                  slash_char: SLASH_RST, digit_zero: ZERO_RST, digit_nine: NINE_RST};
        pr_busy = 1'b0; pr_acc = '0; pr_hasd = 1'b0; pr_idx = '0;
        pr_slash = 1'b0; pr_rec = 1'b0; pr_fmt = FMT_ANY;

        // field sep ',', record sep LF, default dot/slash/digits
        dir_tab = '{
            {"A",    1'b0, 1'b0, FMT_ANY,   1'b1, NO_RES},                    // idle
            {"2",    1'b1, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"5",    1'b0, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"5",    1'b0, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {".",    1'b0, 1'b0, FMT_ANY,   1'b1, mk_res(1, 255, 0, 0, 0, 0, 0)},
            {"0",    1'b0, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"/",    1'b0, 1'b0, FMT_ANY,   1'b1, mk_res(1, 0, 1, 0, 0, 0, 0)},
            {"7",    1'b0, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {",",    1'b0, 1'b0, FMT_ANY,   1'b1, mk_res(1, 7, 2, 1, 0, 3, 1)},
            {".",    1'b1, 1'b0, FMT_ANY,   1'b1, ERR_RES},                   // empty part
            {"0",    1'b1, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"1",    1'b0, 1'b0, FMT_ANY,   1'b1, ERR_RES},                   // leading zero
            {"2",    1'b1, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"5",    1'b0, 1'b0, FMT_ANY,   1'b0, NO_RES},
            {"6",    1'b0, 1'b0, FMT_ANY,   1'b1, ERR_RES},                   // overflow
            {"1",    1'b1, 1'b1, FMT_DOT,   1'b0, NO_RES},
            {",",    1'b0, 1'b1, FMT_DOT,   1'b1, ERR_RES},                   // wrong end
            {"1",    1'b1, 1'b1, FMT_DOT,   1'b0, NO_RES},
            {"/",    1'b0, 1'b1, FMT_DOT,   1'b1, mk_res(1, 1, 0, 0, 0, 0, 0)},
            {"2",    1'b0, 1'b1, FMT_DOT,   1'b0, NO_RES},
            {8'd10,  1'b0, 1'b1, FMT_DOT,   1'b1, ERR_RES},                   // format
            {"3",    1'b1, 1'b1, FMT_SLASH, 1'b0, NO_RES},
            {8'd10,  1'b0, 1'b1, FMT_SLASH, 1'b1, ERR_RES},                   // format
            {"9",    1'b1, 1'b0, 2'd3,      1'b0, NO_RES},
            {8'hFF,  1'b0, 1'b0, 2'd3,      1'b1, ERR_RES},                   // bad char
            {"1",    1'b1, 1'b1, 2'd3,      1'b0, NO_RES},
            {"/",    1'b0, 1'b1, 2'd3,      1'b0, NO_RES},
            {"2",    1'b0, 1'b1, 2'd3,      1'b0, NO_RES},
            {"/",    1'b0, 1'b1, 2'd3,      1'b1, ERR_RES}                    // second slash
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_config(9'd44, 9'd10, DOT_RST, SLASH_RST, ZERO_RST, NINE_RST);
        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].st, dir_tab[i].rec, dir_tab[i].fmt,
                      dir_tab[i].typed, dir_tab[i].res);

        for (ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: set_config(SEP_NONE, 9'd59, DOT_RST, SLASH_RST, ZERO_RST, NINE_RST);
                2: set_config(9'd0, 9'd255, 8'd1, 8'd2, 8'd3, 8'd12);
                3: set_config(9'd44, SEP_NONE, DOT_RST, DOT_RST, ZERO_RST, NINE_RST);
                4: set_config(9'd200, 9'd0, 8'd128, 8'd129, 8'd246, 8'd255);
                5: begin
                    mark = $urandom_range(0, 255);
                    span = $urandom_range(0, 12);
                    set_config($urandom_range(0, 3) == 0 ? SEP_NONE : 9'($urandom_range(0, 255)),
                               $urandom_range(0, 3) == 0 ? SEP_NONE : 9'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'(mark),
                               (mark + span > 255) ? 8'd255 : 8'(mark + span));
                end
                default: set_config(9'd44, 9'd10, DOT_RST, SLASH_RST, 8'd0, 8'd9);
            endcase
            no_idle = (ph == 6);
            if (ph == 2) begin
                @(posedge aclk);
                hold_req = 300;
            end
            mark = value_chars;
            if (ph == 4) send_value(PARTS_MAX + 1, 1'b1);
            while (value_chars - mark < 20) begin
                if ($urandom_range(0, 7) == 0)
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              1'b0, NO_RES);
                else
                    send_value(0, 1'b0);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/ddb_pkg.sv
rtl/ddb_cfg.sv
rtl/ddb_parse.sv
rtl/ddb_out.sv
rtl/dotted_decimal_to_bytes.sv
bench/tb.sv
